// ----- design/dsfh_pkg.sv -----
// Shared types, constants and helper functions for the dual-seed FNV-1a hash unit.
// No dependencies; every other design file imports this package.
package dsfh_pkg;

    localparam int DIGEST_W    = 64;
    localparam int BYTE_W      = 8;
    localparam int CFG_INDEX_W = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_A = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SEED_B = 8'd1;

    localparam logic [63:0] FNV_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] MIX_MUL_A = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_MUL_B = 64'h94D0_49BB_1331_11EB;

    localparam int MIX_SHIFT_0 = 30;
    localparam int MIX_SHIFT_1 = 27;
    localparam int MIX_SHIFT_2 = 31;

    // Partial-product steps of one 64x64 (low half) multiply
    localparam logic [1:0] STEP_LO_LO = 2'd0;
    localparam logic [1:0] STEP_HI_LO = 2'd1;
    localparam logic [1:0] STEP_LO_HI = 2'd2;

    typedef struct packed {
        logic [DIGEST_W-1:0] first;
        logic [DIGEST_W-1:0] second;
    } digest_pair_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_MUL_A,
        B_MUL_B,
        B_OUT
    } back_state_t;

    // FNV-1a step; the prime 2^40 + 0x1b3 reduces to shifts and adds
    function automatic logic [63:0] fnv_fold(input logic [63:0] h, input logic [BYTE_W-1:0] b);
        logic [63:0] x;
        x = h ^ {56'd0, b};
        return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
    endfunction

endpackage

// ----- design/dsfh_byte_if.sv -----
// Byte input channel of the hash unit: one byte of a value and its last mark.
// Depends on dsfh_pkg.
interface dsfh_byte_if
    import dsfh_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;
    logic              last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

// ----- design/dsfh_digest_if.sv -----
// Digest output channel of the hash unit: both finalized digests in one word.
// Depends on dsfh_pkg.
interface dsfh_digest_if
    import dsfh_pkg::*;
();
    logic                valid;
    logic                ready;
    logic [DIGEST_W-1:0] first_digest;
    logic [DIGEST_W-1:0] second_digest;

    modport source (output valid, output first_digest, output second_digest, input ready);
    modport sink   (input valid, input first_digest, input second_digest, output ready);
endinterface

// ----- design/dsfh_cfg_if.sv -----
// Configuration write channel: register index and write data.
// Depends on dsfh_pkg.
interface dsfh_cfg_if
    import dsfh_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [DIGEST_W-1:0]    wdata;

    modport source (output valid, output index, output wdata, input ready);
    modport sink   (input valid, input index, input wdata, output ready);
endinterface

// ----- design/dsfh_front.sv -----
// Front end: seed registers, byte intake and the two running FNV-1a states.
// Pushes the unfinalized pair on each last byte. Depends on dsfh_pkg and the channel interfaces.
module dsfh_front
    import dsfh_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    dsfh_byte_if.sink     byte_in,
    dsfh_cfg_if.sink      cfg,
    output logic          push_valid,
    input  logic          push_ready,
    output digest_pair_t  push_data
);

    logic [DIGEST_W-1:0] seed_a_reg;
    logic [DIGEST_W-1:0] seed_a_next;
    logic [DIGEST_W-1:0] seed_b_reg;
    logic [DIGEST_W-1:0] seed_b_next;
    digest_pair_t        run_reg;
    digest_pair_t        run_next;
    logic                inside_reg;
    logic                inside_next;
    logic                accept;
    digest_pair_t        base;

    assign cfg.ready     = 1'b1;
    assign byte_in.ready = push_ready;
    assign accept        = byte_in.valid && byte_in.ready;

    always_comb
    begin
        seed_a_next = seed_a_reg;
        seed_b_next = seed_b_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_SEED_A: seed_a_next = cfg.wdata;
                CFG_SEED_B: seed_b_next = cfg.wdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        // start a fresh value from basis ^ seed
        if (inside_reg)
        begin
            base = run_reg;
        end
        else
        begin
            base.first  = FNV_BASIS ^ seed_a_reg;
            base.second = FNV_BASIS ^ seed_b_reg;
        end
        run_next.first  = fnv_fold(base.first, byte_in.data_byte);
        run_next.second = fnv_fold(base.second, byte_in.data_byte);
        inside_next     = accept ? !byte_in.last_byte : inside_reg;
    end

    assign push_valid = accept && byte_in.last_byte;
    assign push_data  = run_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_a_reg <= '0;
            seed_b_reg <= '0;
            inside_reg <= 1'b0;
        end
        else
        begin
            seed_a_reg <= seed_a_next;
            seed_b_reg <= seed_b_next;
            inside_reg <= inside_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            run_reg <= run_next;
        end
    end

endmodule

// ----- design/dsfh_fifo.sv -----
// Short queue of unfinalized state pairs between the front and back ends.
// Depends on dsfh_pkg.
module dsfh_fifo
    import dsfh_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push_valid,
    output logic         push_ready,
    input  digest_pair_t push_data,
    output logic         pop_valid,
    input  logic         pop_ready,
    output digest_pair_t pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    digest_pair_t     mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ----- design/dsfh_back.sv -----
// Back end: splitmix64 finalizer for both lanes, one 32x32 partial product per lane
// per cycle, and the digest output register. Depends on dsfh_pkg and dsfh_digest_if.
module dsfh_back
    import dsfh_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           pop_valid,
    output logic           pop_ready,
    input  digest_pair_t   pop_data,
    dsfh_digest_if.source  digest_out
);

    localparam int LANES = 2;

    back_state_t         state_reg;
    back_state_t         state_next;
    logic [1:0]          step_reg;
    logic [1:0]          step_next;
    logic [DIGEST_W-1:0] v_reg    [LANES];
    logic [DIGEST_W-1:0] v_next   [LANES];
    logic [DIGEST_W-1:0] acc_reg  [LANES];
    logic [DIGEST_W-1:0] acc_next [LANES];
    logic [DIGEST_W-1:0] lane_sum [LANES];
    logic [DIGEST_W-1:0] lane_in  [LANES];
    logic [DIGEST_W-1:0] mul_k;
    logic [31:0]         op_a     [LANES];
    logic [31:0]         op_k;
    logic                op_shift;
    logic [63:0]         prod     [LANES];

    assign lane_in[0] = pop_data.first;
    assign lane_in[1] = pop_data.second;

    // operand select for this partial product
    always_comb
    begin
        mul_k = (state_reg == B_MUL_A) ? MIX_MUL_A : MIX_MUL_B;
        op_k     = mul_k[31:0];
        op_shift = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            op_a[i] = v_reg[i][31:0];
        end
        case (step_reg)
            STEP_LO_LO:
            begin
                op_k     = mul_k[31:0];
                op_shift = 1'b0;
            end
            STEP_HI_LO:
            begin
                op_k     = mul_k[31:0];
                op_shift = 1'b1;
                for (int i = 0; i < LANES; i++)
                begin
                    op_a[i] = v_reg[i][63:32];
                end
            end
            STEP_LO_HI:
            begin
                op_k     = mul_k[63:32];
                op_shift = 1'b1;
            end
            default:
            begin
                op_k     = mul_k[31:0];
                op_shift = 1'b0;
            end
        endcase
        for (int i = 0; i < LANES; i++)
        begin
            prod[i]     = {32'd0, op_a[i]} * {32'd0, op_k};
            lane_sum[i] = acc_reg[i] + (op_shift ? {prod[i][31:0], 32'd0} : prod[i]);
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        step_next        = step_reg;
        pop_ready        = 1'b0;
        digest_out.valid = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            v_next[i]   = v_reg[i];
            acc_next[i] = acc_reg[i];
        end
        case (state_reg)
            B_IDLE:
            begin
                pop_ready = 1'b1;
                if (pop_valid)
                begin
                    for (int i = 0; i < LANES; i++)
                    begin
                        v_next[i]   = lane_in[i] ^ (lane_in[i] >> MIX_SHIFT_0);
                        acc_next[i] = '0;
                    end
                    step_next  = STEP_LO_LO;
                    state_next = B_MUL_A;
                end
            end
            B_MUL_A, B_MUL_B:
            begin
                for (int i = 0; i < LANES; i++)
                begin
                    acc_next[i] = lane_sum[i];
                end
                case (step_reg)
                    STEP_LO_LO: step_next = STEP_HI_LO;
                    STEP_HI_LO: step_next = STEP_LO_HI;
                    default:
                    begin
                        // product done: apply the shift-xor and move on
                        step_next = STEP_LO_LO;
                        for (int i = 0; i < LANES; i++)
                        begin
                            acc_next[i] = '0;
                            if (state_reg == B_MUL_A)
                            begin
                                v_next[i] = lane_sum[i] ^ (lane_sum[i] >> MIX_SHIFT_1);
                            end
                            else
                            begin
                                v_next[i] = lane_sum[i] ^ (lane_sum[i] >> MIX_SHIFT_2);
                            end
                        end
                        state_next = (state_reg == B_MUL_A) ? B_MUL_B : B_OUT;
                    end
                endcase
            end
            B_OUT:
            begin
                digest_out.valid = 1'b1;
                if (digest_out.ready)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    assign digest_out.first_digest  = v_reg[0];
    assign digest_out.second_digest = v_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            step_reg  <= STEP_LO_LO;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            v_reg[i]   <= v_next[i];
            acc_reg[i] <= acc_next[i];
        end
    end

endmodule

// ----- design/dual_seed_fnv1a_mix_hash_unit.sv -----
// Top level of the dual-seed FNV-1a hash unit with splitmix64 finalizer.
// Depends on dsfh_pkg, the channel interfaces, dsfh_front, dsfh_fifo and dsfh_back.
//
// Usage:
//   byte_in    : one byte per word, tag byte first, then the little-endian value
//                bytes; last_byte marks the final byte of a value.
//   cfg        : writes the first seed (index 0) or the second seed (index 1);
//                always ready. A seed takes effect at the first byte of the next value.
//   digest_out : one word per value carrying both finalized digests.
// Throughput: the front folds one byte per cycle into both FNV states while the queue
// is not full (shift-add multiply by the FNV prime). Finalizing a value in the back end
// takes a pop state, two 64-bit multiplies of three 32x32 partial products each, and
// an output state; the back end runs one value at a time on one 32x32 multiplier
// per lane. Values shorter than 8 bytes are therefore limited by the finalizer.
// With an idle queue, a digest shows after the pop state and both multiplies.
// The queue between the ends holds QUEUE_DEPTH finished states; byte_in.ready drops
// while it is full. When the receiver stalls, the digest word holds, the queue fills,
// and then byte intake stalls.
// Reset clears the seeds to zero, drops any partly received value and empties the queue.
module dual_seed_fnv1a_mix_hash_unit
    import dsfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    dsfh_byte_if.sink      byte_in,
    dsfh_cfg_if.sink       cfg,
    dsfh_digest_if.source  digest_out
);

    logic         push_valid;
    logic         push_ready;
    digest_pair_t push_data;
    logic         pop_valid;
    logic         pop_ready;
    digest_pair_t pop_data;

    dsfh_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .cfg        (cfg),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    dsfh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    dsfh_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data),
        .digest_out (digest_out)
    );

endmodule

// ----- design/dsfh_checker.sv -----
// Port-level checks for the hash unit, bound to the top level.
// Depends on dsfh_pkg and dual_seed_fnv1a_mix_hash_unit.
module dsfh_checker
    import dsfh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                in_last,
    input logic                out_valid,
    input logic                out_ready,
    input logic [DIGEST_W-1:0] out_first,
    input logic [DIGEST_W-1:0] out_second
);

    localparam int CAP   = QUEUE_DEPTH + 1;
    localparam int PEND_W = $clog2(CAP + 1);
    localparam logic [PEND_W-1:0] CAP_CNT = PEND_W'(CAP);

    logic [PEND_W-1:0] pending_reg;
    logic [PEND_W-1:0] pending_next;
    logic              end_in;
    logic              word_out;

    assign end_in   = in_valid && in_ready && in_last;
    assign word_out = out_valid && out_ready;

    // values taken but not yet delivered
    always_comb
    begin
        pending_next = pending_reg;
        if (end_in && !word_out)
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (word_out && !end_in)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_first) && $stable(out_second))
        else $error("digest word changed while stalled");

    a_owed_result: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pending_reg != '0)
        else $error("digest word with no value pending");

    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg == CAP_CNT |-> !in_ready)
        else $error("byte taken with queue and finalizer full");

    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        end_in && pending_reg == '0 |=> !out_valid)
        else $error("digest appeared in the cycle after the last byte");

endmodule

bind dual_seed_fnv1a_mix_hash_unit dsfh_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_dsfh_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (byte_in.valid),
    .in_ready   (byte_in.ready),
    .in_last    (byte_in.last_byte),
    .out_valid  (digest_out.valid),
    .out_ready  (digest_out.ready),
    .out_first  (digest_out.first_digest),
    .out_second (digest_out.second_digest)
);

// ----- bench/dsfh_hash_checker.sv -----
`timescale 1ns / 100ps
// Digest checker for the dual-seed FNV-1a hash unit: watches the byte, config and
// digest channels, predicts both digests of every value and compares them in order.
// Depends on dsfh_pkg and the three channel interfaces.
module dsfh_hash_checker
    import dsfh_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    dsfh_byte_if   byte_tap,
    dsfh_cfg_if    cfg_tap,
    dsfh_digest_if digest_tap,
    output int     fail_count,
    output int     digests_due
);

    localparam logic [63:0] OFFSET_BASIS = 64'd1469598103934665603;
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [63:0] MIX_A        = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [63:0] MIX_B        = 64'h94D0_49BB_1331_11EB;

    logic [63:0]  seed_a_q;
    logic [63:0]  seed_b_q;
    logic [63:0]  first_hash;
    logic [63:0]  second_hash;
    logic         mid_value;
    digest_pair_t expected_digests[$];
    int           errors;

    function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
        return (h ^ {56'd0, b}) * FNV_PRIME;
    endfunction

    function automatic logic [63:0] splitmix_finish(input logic [63:0] v);
        logic [63:0] m;
        m = v ^ (v >> 30);
        m = m * MIX_A;
        m = m ^ (m >> 27);
        m = m * MIX_B;
        return m ^ (m >> 31);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        digest_pair_t want;
        if (!rst_n)
        begin
            seed_a_q    = '0;
            seed_b_q    = '0;
            first_hash  = '0;
            second_hash = '0;
            mid_value   = 1'b0;
            expected_digests.delete();
            errors      = 0;
        end
        else
        begin
            if (cfg_tap.valid && cfg_tap.ready)
            begin
                case (cfg_tap.index)
                    CFG_SEED_A: seed_a_q = cfg_tap.wdata;
                    CFG_SEED_B: seed_b_q = cfg_tap.wdata;
                    default: ;
                endcase
            end

            if (byte_tap.valid && byte_tap.ready)
            begin
                // seeds are picked up only at the tag byte
                if (!mid_value)
                begin
                    first_hash  = OFFSET_BASIS ^ seed_a_q;
                    second_hash = OFFSET_BASIS ^ seed_b_q;
                end
                first_hash  = fnv_step(first_hash, byte_tap.data_byte);
                second_hash = fnv_step(second_hash, byte_tap.data_byte);
                mid_value   = !byte_tap.last_byte;
                if (byte_tap.last_byte)
                begin
                    want.first  = splitmix_finish(first_hash);
                    want.second = splitmix_finish(second_hash);
                    expected_digests.push_back(want);
                end
            end

            if (digest_tap.valid && digest_tap.ready)
            begin
                if (expected_digests.size() == 0)
                begin
                    $display("%0t unexpected digest word: first %h second %h", $time,
                             digest_tap.first_digest, digest_tap.second_digest);
                    errors++;
                end
                else
                begin
                    want = expected_digests.pop_front();
                    if (digest_tap.first_digest !== want.first)
                    begin
                        $display("%0t first_digest expected %h actual %h", $time,
                                 want.first, digest_tap.first_digest);
                        errors++;
                    end
                    if (digest_tap.second_digest !== want.second)
                    begin
                        $display("%0t second_digest expected %h actual %h", $time,
                                 want.second, digest_tap.second_digest);
                        errors++;
                    end
                end
            end
        end
        fail_count  <= errors;
        digests_due <= expected_digests.size();
    end

endmodule

// ----- bench/tb_dual_seed_fnv1a_mix_hash_unit.sv -----
`timescale 1ns / 100ps
// Stimulus and verdict for the dual-seed FNV-1a hash unit: byte streams of values
// under several seed settings, with random gaps and receiver stalls.
// Depends on dsfh_pkg, the channel interfaces, the hash unit and dsfh_hash_checker.
module tb_dual_seed_fnv1a_mix_hash_unit;
    import dsfh_pkg::*;

    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 24;
    localparam int BYTES_PER_PHASE  = 290;
    localparam int STEADY_PHASE     = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_INDEX = CFG_SEED_B + 1'b1;

    typedef enum int {FILL_ZERO, FILL_ONES, FILL_RAMP, FILL_RANDOM} fill_kind_t;

    logic clk;
    logic rst_n;
    logic steady;
    int   cycles;
    int   fail_count;
    int   digests_due;

    dsfh_byte_if   byte_ch();
    dsfh_cfg_if    cfg_ch();
    dsfh_digest_if digest_ch();

    dual_seed_fnv1a_mix_hash_unit dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_ch),
        .cfg        (cfg_ch),
        .digest_out (digest_ch)
    );

    dsfh_hash_checker checker_i (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_tap    (byte_ch),
        .cfg_tap     (cfg_ch),
        .digest_tap  (digest_ch),
        .fail_count  (fail_count),
        .digests_due (digests_due)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver stalls about 13 percent of the time, never in the steady phase
    always @(negedge clk)
    begin
        digest_ch.ready = steady || ($urandom_range(99) >= 13);
    end

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (!steady && $urandom_range(99) < 13)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid     = 1'b1;
        byte_ch.data_byte = b;
        byte_ch.last_byte = last;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // tag byte first, then len-1 value bytes; last mark on the final one
    task automatic send_value(input int len, input fill_kind_t kind);
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            case (kind)
                FILL_ZERO: b = 8'h00;
                FILL_ONES: b = 8'hFF;
                FILL_RAMP: b = 8'(i * 37 + 1);
                default:   b = 8'($urandom_range(255));
            endcase
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [63:0] value);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = idx;
        cfg_ch.wdata = value;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    // drain all digests, then let the finalizer settle before touching the seeds
    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (digests_due != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic random_values(input int budget);
        int len;
        int pick;
        while (budget > 0)
        begin
            pick = $urandom_range(99);
            if (pick < 10)
                len = 1;
            else if (pick < 75)
                len = $urandom_range(9, 2);
            else
                len = $urandom_range(24, 10);
            send_value(len, FILL_RANDOM);
            budget -= len;
        end
    endtask

    initial
    begin
        logic [63:0] rnd_seed;
        rst_n             = 1'b0;
        steady            = 1'b0;
        byte_ch.valid     = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.last_byte = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_SEED_A;
        cfg_ch.wdata      = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed values under the reset seeds
        send_value(1, FILL_ZERO);
        send_value(1, FILL_ONES);
        send_value(9, FILL_ONES);
        send_value(5, FILL_ZERO);
        send_value(7, FILL_RAMP);
        send_value(2, FILL_RANDOM);

        for (int phase = 0; phase < 6; phase++)
        begin
            if (phase > 0)
            begin
                wait_drained();
                rnd_seed = {$urandom(), $urandom()};
                case (phase)
                    1:
                    begin
                        write_reg(CFG_SEED_A, '1);
                        write_reg(CFG_SEED_B, '0);
                    end
                    2:
                    begin
                        write_reg(CFG_SEED_A, '0);
                        write_reg(CFG_SEED_B, '1);
                    end
                    3:
                    begin
                        // seed equal to the basis starts the running hash at zero
                        write_reg(CFG_SEED_A, FNV_BASIS);
                        write_reg(CFG_SEED_B, rnd_seed);
                        write_reg(CFG_SPARE_INDEX, {$urandom(), $urandom()});
                    end
                    4:
                    begin
                        write_reg(CFG_SEED_A, rnd_seed);
                        write_reg(CFG_SEED_B, {$urandom(), $urandom()});
                    end
                    default:
                    begin
                        write_reg(CFG_SEED_A, {$urandom(), $urandom()});
                        write_reg(CFG_SEED_B, FNV_BASIS);
                    end
                endcase
            end
            steady = (phase == STEADY_PHASE);
            if (phase == 5)
            begin
                send_value(1, FILL_ONES);
                send_value(9, FILL_ZERO);
            end
            random_values(phase == 0 ? BYTES_PER_PHASE - 25 : BYTES_PER_PHASE);
        end
        steady = 1'b0;

        wait_drained();
        if (fail_count == 0 && digests_due == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
